>>> design/msd_pkg.sv
// Shared types, constants and the glyph decoder for the seven-segment display driver.
// Used by msd_ctrl, msd_dp and multiplexed_seven_segment_driver. No dependencies.
package msd_pkg;

	localparam int NUM_DIGITS = 4;
	localparam int DIGIT_W    = 4;
	localparam int VALUE_W    = 14;
	localparam int IDX_W      = 2;
	localparam int EN_W       = 4;
	localparam int SEG_W      = 8;
	localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
	localparam int STEP_W     = 4;

	localparam logic [VALUE_W-1:0] LOAD_LIMIT  = VALUE_W'(9999);
	localparam logic [SEG_W-1:0]   ERROR_GLYPH = 8'b1111_1101;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [VALUE_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic [EN_W-1:0]  digit_enable;
		logic [SEG_W-1:0] segment_pattern;
	} disp_item_t;

	typedef struct packed {
		logic start;
		logic step;
		logic commit;
		logic tick;
	} dp_cmd_t;

	typedef struct packed {
		logic out_blocked;
	} dp_status_t;

	// Segment order is dp g f e d c b a; anything above nine shows the error glyph.
	function automatic logic [SEG_W-1:0] glyph_of(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] seg;
		unique case (d)
			4'd0:    seg = 8'b0011_1111;
			4'd1:    seg = 8'b0000_0110;
			4'd2:    seg = 8'b0101_1011;
			4'd3:    seg = 8'b0100_1111;
			4'd4:    seg = 8'b0110_0110;
			4'd5:    seg = 8'b0110_1101;
			4'd6:    seg = 8'b0111_1101;
			4'd7:    seg = 8'b0000_0111;
			4'd8:    seg = 8'b0111_1111;
			4'd9:    seg = 8'b0110_1111;
			default: seg = ERROR_GLYPH;
		endcase
		return seg;
	endfunction

endpackage

>>> design/msd_ctrl.sv
// Controller for the seven-segment display driver: accepts items and sequences the
// binary-to-decimal conversion steps. Depends on msd_pkg.
module msd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  msd_pkg::req_item_t  req,
	output logic                req_stall,
	input  msd_pkg::dp_status_t status,
	output msd_pkg::dp_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_COMMIT
	} state_t;

	state_t                      state_q;
	logic [msd_pkg::STEP_W-1:0]  step_q;
	logic                        accept;
	logic                        is_tick;
	logic                        load_ok;

	assign req_stall = (state_q != ST_IDLE) || status.out_blocked;
	assign accept    = req_valid && !req_stall;
	assign is_tick   = (req.req_type == msd_pkg::REQ_TICK);
	assign load_ok   = !is_tick && (req.value <= msd_pkg::LOAD_LIMIT);

	always_comb begin
		cmd.start  = accept && load_ok;
		cmd.tick   = accept && is_tick;
		cmd.step   = (state_q == ST_CONV);
		cmd.commit = (state_q == ST_COMMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (accept && load_ok) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (step_q == msd_pkg::STEP_W'(msd_pkg::VALUE_W - 1)) begin
						state_q <= ST_COMMIT;
					end
					step_q <= step_q + msd_pkg::STEP_W'(1);
				end
				ST_COMMIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/msd_dp.sv
// Datapath for the seven-segment display driver: shift-add-3 converter, digit store,
// scan index and the output register. Depends on msd_pkg.
module msd_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msd_pkg::dp_cmd_t     cmd,
	input  msd_pkg::req_item_t   req,
	output msd_pkg::dp_status_t  status,
	output logic                 disp_valid,
	input  logic                 disp_stall,
	output msd_pkg::disp_item_t  disp
);

	logic [msd_pkg::BCD_W-1:0]   bcd_q;
	logic [msd_pkg::VALUE_W-1:0] bin_q;
	logic [msd_pkg::BCD_W-1:0]   bcd_adj;
	logic [msd_pkg::DIGIT_W-1:0] digits_q [msd_pkg::NUM_DIGITS];
	logic [msd_pkg::IDX_W-1:0]   idx_q;
	logic [msd_pkg::IDX_W-1:0]   idx_next;
	logic                        out_valid_q;
	msd_pkg::disp_item_t         out_item_q;

	// Each decimal nibble of five or more gets three added before the shift.
	always_comb begin
		for (int k = 0; k < msd_pkg::NUM_DIGITS; k++) begin
			logic [msd_pkg::DIGIT_W-1:0] nib;
			nib = bcd_q[k*msd_pkg::DIGIT_W +: msd_pkg::DIGIT_W];
			bcd_adj[k*msd_pkg::DIGIT_W +: msd_pkg::DIGIT_W] =
				(nib >= msd_pkg::DIGIT_W'(5)) ? nib + msd_pkg::DIGIT_W'(3) : nib;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			bcd_q <= '0;
			bin_q <= req.value;
		end else if (cmd.step) begin
			bcd_q <= {bcd_adj[msd_pkg::BCD_W-2:0], bin_q[msd_pkg::VALUE_W-1]};
			bin_q <= {bin_q[msd_pkg::VALUE_W-2:0], 1'b0};
		end
	end

	assign idx_next = (idx_q == msd_pkg::IDX_W'(msd_pkg::NUM_DIGITS - 1))
		? '0 : idx_q + msd_pkg::IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < msd_pkg::NUM_DIGITS; k++) begin
				digits_q[k] <= '0;
			end
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				for (int k = 0; k < msd_pkg::NUM_DIGITS; k++) begin
					digits_q[k] <= bcd_q[k*msd_pkg::DIGIT_W +: msd_pkg::DIGIT_W];
				end
			end
			if (cmd.tick) begin
				idx_q       <= idx_next;
				out_valid_q <= 1'b1;
			end else if (!disp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			out_item_q.digit_enable    <= msd_pkg::EN_W'(1) << idx_next;
			out_item_q.segment_pattern <= msd_pkg::glyph_of(digits_q[idx_next]);
		end
	end

	assign status.out_blocked = out_valid_q && disp_stall;
	assign disp_valid         = out_valid_q;
	assign disp               = out_item_q;

endmodule

>>> design/multiplexed_seven_segment_driver.sv
// Top level of the multiplexed four-digit seven-segment display driver.
// Depends on msd_pkg, msd_ctrl and msd_dp.
//
// Usage:
//   The request channel (req_valid, req_stall, req) takes two kinds of item.
//   A load item (req_type = 0) carries a 14-bit binary number. A number of 9999
//   or less is converted to four decimal digits that replace the shown digits;
//   a larger number is dropped and leaves the digits as they were. A load never
//   produces a result item.
//   A tick item (req_type = 1) advances the scan index (3 wraps to 0) and produces
//   one result on the display channel (disp_valid, disp_stall, disp): a one-hot
//   digit enable and the dp-g-f-e-d-c-b-a segment pattern of that digit.
//   The decimal point is never lit.
//
// Timing:
//   A tick's result appears in the cycle after the tick is accepted, and another tick
//   may follow at once while the result register is free or being emptied.
//   A load that is converted goes through the accepting cycle, 14 shift-add-3 steps
//   of the converter (one input bit per cycle) and a write of the digit store.
//   req_stall is high during the steps and the write. An out-of-range load is
//   dropped without raising req_stall.
//   While the receiver holds disp_stall, the result stays put and req_stall rises,
//   so no further item is taken until the result has been delivered.
//
// Reset (arst_n low, asynchronous) clears all digits to zero, the scan index to
// zero and the result register to empty; the first tick shows digit 1.
module multiplexed_seven_segment_driver (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  msd_pkg::req_item_t  req,
	output logic                disp_valid,
	input  logic                disp_stall,
	output msd_pkg::disp_item_t disp
);

	msd_pkg::dp_cmd_t    cmd;
	msd_pkg::dp_status_t status;

	// Sequencer: handles the request handshake and steps the converter.
	msd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Converter, digit store, scan index and the result register.
	msd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req        (req),
		.status     (status),
		.disp_valid (disp_valid),
		.disp_stall (disp_stall),
		.disp       (disp)
	);

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multiplexed seven-segment display driver.
// Depends on msd_pkg and multiplexed_seven_segment_driver; needs no other file.
module tb_top;

	// One row of the directed table. Where "typed" is set, the expected display
	// item is written out by hand. Otherwise the digit predictor supplies it.
	typedef struct {
		msd_pkg::req_item_t  r;
		bit                  typed;
		msd_pkg::disp_item_t want;
	} dir_row_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                req_valid  = 1'b0;
	logic                req_stall;
	msd_pkg::req_item_t  req        = '0;
	logic                disp_valid;
	logic                disp_stall = 1'b0;
	msd_pkg::disp_item_t disp;

	// The predictor keeps its own copy of the digit store and the scan position.
	logic [msd_pkg::DIGIT_W-1:0] shown_digits [msd_pkg::NUM_DIGITS];
	logic [msd_pkg::IDX_W-1:0]   scan_pos;

	// These are the display items still owed by the block, oldest first.
	msd_pkg::disp_item_t pending_disp [$];
	dir_row_t            directed_rows [$];
	int                  err_count   = 0;

	// These flags are set by the sender. "calm" turns idling off on both sides.
	// "hold_wanted" asks the receiver for its single long hold-off.
	bit         calm        = 1'b0;
	bit         hold_wanted = 1'b0;

	multiplexed_seven_segment_driver u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.disp_valid (disp_valid),
		.disp_stall (disp_stall),
		.disp       (disp)
	);

	// The clock has a 12 ns period. Inputs move on the falling edge and outputs
	// are sampled on the rising edge, so the two never race.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report(input string what);
		err_count++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	// Segment order is dp g f e d c b a. The decimal point stays dark for the digits zero to nine.
	function automatic logic [msd_pkg::SEG_W-1:0] segments_for(
			input logic [msd_pkg::DIGIT_W-1:0] d);
		case (d)
			4'd0:    return 8'h3F;
			4'd1:    return 8'h06;
			4'd2:    return 8'h5B;
			4'd3:    return 8'h4F;
			4'd4:    return 8'h66;
			4'd5:    return 8'h6D;
			4'd6:    return 8'h7D;
			4'd7:    return 8'h07;
			4'd8:    return 8'h7F;
			4'd9:    return 8'h6F;
			default: return msd_pkg::ERROR_GLYPH;
		endcase
	endfunction

	// This is the predictor. A load in range rewrites every digit, least
	// significant first, and a load out of range changes nothing. A tick first
	// advances the scan position and then shows the digit that it now points at.
	task automatic advance_display(input msd_pkg::req_item_t r, output bit lit,
			output msd_pkg::disp_item_t shown);
		int unsigned v;
		logic [msd_pkg::DIGIT_W-1:0] d;
		lit   = 1'b0;
		shown = '0;
		v     = 32'(r.value);
		if (r.req_type == msd_pkg::REQ_LOAD) begin
			if (r.value <= msd_pkg::LOAD_LIMIT) begin
				for (int k = 0; k < msd_pkg::NUM_DIGITS; k++) begin
					shown_digits[k] = msd_pkg::DIGIT_W'(v % 10);
					v = v / 10;
				end
			end
		end else begin
			scan_pos = (scan_pos == msd_pkg::IDX_W'(msd_pkg::NUM_DIGITS - 1))
				? '0 : scan_pos + msd_pkg::IDX_W'(1);
			d = shown_digits[scan_pos];
			shown.digit_enable    = msd_pkg::EN_W'(1) << scan_pos;
			shown.segment_pattern = segments_for(d);
			lit = 1'b1;
		end
	endtask

	task automatic add_row(input logic kind, input int unsigned v, input bit typed,
			input logic [msd_pkg::EN_W-1:0] en, input logic [msd_pkg::SEG_W-1:0] seg);
		dir_row_t row;
		row.r.req_type             = kind;
		row.r.value                = msd_pkg::VALUE_W'(v);
		row.typed                  = typed;
		row.want.digit_enable      = en;
		row.want.segment_pattern   = seg;
		directed_rows.push_back(row);
	endtask

	// This task is entered and left on a falling edge. It may idle at random
	// first. It then holds the item until the block takes it.
	task automatic send_item(input msd_pkg::req_item_t r, input bit typed,
			input msd_pkg::disp_item_t want);
		bit lit;
		msd_pkg::disp_item_t shown;
		while (!calm && $urandom_range(99) < 8) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (req_stall === 1'b0)
				break;
		end
		advance_display(r, lit, shown);
		if (lit)
			pending_disp.push_back(typed ? want : shown);
		@(negedge clk);
	endtask

	// This is the receiver. It mostly stalls at random. Once it is asked, it
	// holds disp_stall for a long stretch, counted here. The result register
	// then stays full and the block has to push back on the request side.
	initial begin : disp_side
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_wanted && !hold_done) begin
				hold_left = 300;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				disp_stall <= 1'b1;
				hold_left--;
			end else begin
				disp_stall <= calm ? 1'b0 : ($urandom_range(99) < 8);
			end
		end
	end

	// Each display item that is accepted is compared with the oldest expectation.
	always @(posedge clk) begin : check_disp
		msd_pkg::disp_item_t want;
		if (disp_valid === 1'b1 && disp_stall === 1'b0) begin
			if (pending_disp.size() == 0) begin
				report($sformatf("display item %h with nothing expected", disp));
			end else begin
				want = pending_disp.pop_front();
				if (disp.digit_enable !== want.digit_enable)
					report($sformatf("digit_enable %b, expected %b",
						disp.digit_enable, want.digit_enable));
				if (disp.segment_pattern !== want.segment_pattern)
					report($sformatf("segment_pattern %b, expected %b",
						disp.segment_pattern, want.segment_pattern));
			end
		end
	end

	initial begin : stimulus
		msd_pkg::req_item_t r;
		int unsigned pick;
		for (int k = 0; k < msd_pkg::NUM_DIGITS; k++)
			shown_digits[k] = '0;
		scan_pos = '0;

		// After reset every digit is zero. The first tick lands on digit 1,
		// and the fourth tick wraps around to digit 0.
		add_row(msd_pkg::REQ_TICK, 0,     1'b1, 4'b0010, 8'h3F);
		add_row(msd_pkg::REQ_TICK, 0,     1'b1, 4'b0100, 8'h3F);
		add_row(msd_pkg::REQ_TICK, 0,     1'b1, 4'b1000, 8'h3F);
		add_row(msd_pkg::REQ_TICK, 0,     1'b1, 4'b0001, 8'h3F);
		// This is the largest number that is shown: every digit is a nine.
		add_row(msd_pkg::REQ_LOAD, 9999,  1'b0, '0, '0);
		add_row(msd_pkg::REQ_TICK, 0,     1'b1, 4'b0010, 8'h6F);
		add_row(msd_pkg::REQ_TICK, 0,     1'b1, 4'b0100, 8'h6F);
		add_row(msd_pkg::REQ_TICK, 0,     1'b1, 4'b1000, 8'h6F);
		add_row(msd_pkg::REQ_TICK, 0,     1'b1, 4'b0001, 8'h6F);
		// Loads above the limit, the top of the field among them, are dropped.
		add_row(msd_pkg::REQ_LOAD, 16383, 1'b0, '0, '0);
		add_row(msd_pkg::REQ_TICK, 16383, 1'b1, 4'b0010, 8'h6F);
		add_row(msd_pkg::REQ_LOAD, 10000, 1'b0, '0, '0);
		add_row(msd_pkg::REQ_TICK, 0,     1'b1, 4'b0100, 8'h6F);
		// A zero load clears every digit.
		add_row(msd_pkg::REQ_LOAD, 0,     1'b0, '0, '0);
		add_row(msd_pkg::REQ_TICK, 0,     1'b1, 4'b1000, 8'h3F);
		// The next loads have mixed digits and leading zeros.
		add_row(msd_pkg::REQ_LOAD, 1234,  1'b0, '0, '0);
		add_row(msd_pkg::REQ_TICK, 0,     1'b0, '0, '0);
		add_row(msd_pkg::REQ_TICK, 0,     1'b0, '0, '0);
		add_row(msd_pkg::REQ_TICK, 0,     1'b0, '0, '0);
		add_row(msd_pkg::REQ_TICK, 0,     1'b0, '0, '0);
		add_row(msd_pkg::REQ_LOAD, 9,     1'b0, '0, '0);
		add_row(msd_pkg::REQ_TICK, 0,     1'b0, '0, '0);
		add_row(msd_pkg::REQ_LOAD, 8191,  1'b0, '0, '0);
		add_row(msd_pkg::REQ_TICK, 0,     1'b0, '0, '0);
		add_row(msd_pkg::REQ_TICK, 0,     1'b0, '0, '0);

		// Reset is released on a falling edge.
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].want);

		// The random part is mostly ticks, with loads in between. Most loads are
		// in range, some are small numbers and some are above the limit.
		// Items 500 to 799 run without any idling. From item 1000 on, the
		// receiver is asked for its long hold-off.
		for (int n = 0; n < 1525; n++) begin
			calm        = (n >= 500 && n < 800);
			hold_wanted = (n >= 1000);
			pick        = $urandom_range(99);
			if (pick < 40) begin
				r.req_type = msd_pkg::REQ_LOAD;
				pick = $urandom_range(99);
				if (pick < 75)
					r.value = msd_pkg::VALUE_W'($urandom_range(9999));
				else if (pick < 88)
					r.value = msd_pkg::VALUE_W'($urandom_range(99));
				else
					r.value = msd_pkg::VALUE_W'($urandom_range(16383, 10000));
			end else begin
				r.req_type = msd_pkg::REQ_TICK;
				r.value    = msd_pkg::VALUE_W'($urandom_range(16383));
			end
			send_item(r, 1'b0, '0);
		end
		req_valid <= 1'b0;

		// The run drains the owed items and then keeps watching for stray output
		// before it ends.
		while (pending_disp.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// This watchdog sits far beyond the slowest correct run, which is a few
	// hundred microseconds.
	initial begin : watchdog
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
